// ===== rtl/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared constants and types for the delay-line pitch shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

  localparam int DELAY_DEPTH_DEF   = 2048;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SAMPLE_W = 32;
  localparam int FRAME_W  = 64;
  localparam int RATIO_W  = 18;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd78643;

  // where each tap of an item comes from
  typedef struct packed {
    logic lo_fwd;  // low tap is the entry written by this item
    logic lo_hit;  // low tap holds a written sample
    logic hi_fwd;
    logic hi_hit;
  } dlps_tag_t;

endpackage

// ===== rtl/dlps_store.sv =====
// ----------------------------------------------------------------------------
// dlps_store
// Sample store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dlps_store #(
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DELAY_DEPTH)-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic                          re,
  input  logic [$clog2(DELAY_DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DELAY_DEPTH)-1:0] raddr_b,
  output logic [31:0]                   rdata_a,
  output logic [31:0]                   rdata_b
);

  logic [31:0] mem [DELAY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/dlps_interp.sv =====
// ----------------------------------------------------------------------------
// dlps_interp
// Tap selection, linear interpolation, saturation and output register.
// ----------------------------------------------------------------------------
module dlps_interp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              sample,
  input  logic [FRACTION_BITS-1:0] frac,
  input  dlps_pkg::dlps_tag_t      tag,
  input  logic [31:0]              rd_a,
  input  logic [31:0]              rd_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [63:0]              frame_out
);
  import dlps_pkg::*;

  localparam int PRW = 33 + FRACTION_BITS + 1;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [31:0]              sample1;
  logic [FRACTION_BITS-1:0] frac1;
  dlps_tag_t                tag1;

  logic signed [31:0]       a2;
  logic signed [32:0]       diff2;
  logic [FRACTION_BITS-1:0] frac2;

  logic signed [31:0]       a3;
  logic signed [PRW-1:0]    prod3;

  logic [31:0]              a_s, b_s;
  logic signed [PRW-1:0]    scaled;
  logic signed [33:0]       sum;
  logic [31:0]              y;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_comb begin
    a_s = tag1.lo_fwd ? sample1 : (tag1.lo_hit ? rd_a : 32'd0);
    b_s = tag1.hi_fwd ? sample1 : (tag1.hi_hit ? rd_b : 32'd0);
  end

  always_comb begin
    scaled = prod3 >>> FRACTION_BITS;
    sum    = 34'(a3) + scaled[33:0];
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      y = sum[31:0];
    end else if (sum[33]) begin
      y = 32'h8000_0000;
    end else begin
      y = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sample1 <= sample;
      frac1   <= frac;
      tag1    <= tag;
    end
    if (rdy2 && v1) begin
      a2    <= $signed(a_s);
      diff2 <= $signed({b_s[31], b_s}) - $signed({a_s[31], a_s});
      frac2 <= frac1;
    end
    if (rdy3 && v2) begin
      a3    <= a2;
      prod3 <= diff2 * $signed({1'b0, frac2});
    end
    if (rdy4 && v3) begin
      frame_out <= {y, y};
    end
  end

  a_out_halves : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_out[63:32] == frame_out[31:0])
    else $error("output halves differ");

  a_hold_s2 : assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> (v2 && $stable(diff2) && $stable(a2)))
    else $error("stage two lost its item");

  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && out_valid))
    else $error("ready low with a free stage");

endmodule

// ===== rtl/delay_line_pitch_shifter.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Circular sample store read at a fractional position with linear
// interpolation; result repeated in both halves of the output frame.
//
//   channel  signals                         handshake
//   input    in_valid in_ready frame_in      valid/ready
//   output   out_valid out_ready frame_out   valid/ready
//   config   cfg_we cfg_wdata                write enable, no wait
//
// One item per cycle sustained while out_ready is high; out_valid follows the
// accept through four register stages (store read, tap select and subtract,
// multiply, add and saturate).
// The store has one write and two read ports, so write and both taps fit
// in the accept cycle. Reset is synchronous; a fill count makes unwritten
// entries read as zero, so no clearing pass is needed. An output stall
// fills the pipeline bubbles first, then drops in_ready.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter #(
  parameter int DELAY_DEPTH   = dlps_pkg::DELAY_DEPTH_DEF,
  parameter int FRACTION_BITS = dlps_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dlps_pkg::FRAME_W-1:0]  frame_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dlps_pkg::FRAME_W-1:0]  frame_out,
  input  logic                          cfg_we,
  input  logic [dlps_pkg::RATIO_W-1:0]  cfg_wdata
);
  import dlps_pkg::*;

  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int PW        = AW + FRACTION_BITS;
  localparam int RW        = ((PW > RATIO_W) ? PW : RATIO_W) + 1;
  localparam int RED_STEPS = (RATIO_W >= PW) ? (RATIO_W - PW + 1) : 0;
  localparam logic [RW-1:0] SPAN = RW'(DELAY_DEPTH) << FRACTION_BITS;
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]   FULL = (AW + 1)'(DELAY_DEPTH);

  // ratio modulo the position span, by restoring subtraction
  function automatic logic [PW-1:0] reduce_ratio(input logic [RATIO_W-1:0] v);
    logic [RW-1:0] r;
    r = RW'(v);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (r >= (SPAN << k)) r = r - (SPAN << k);
    end
    return r[PW-1:0];
  endfunction

  logic [PW-1:0] ratio;
  logic [PW-1:0] read_position, read_position_next;
  logic [AW-1:0] write_index, write_index_next;
  logic [AW:0]   fill;

  logic [AW-1:0] lo_idx, hi_idx;
  logic [PW:0]   pos_sum;
  dlps_tag_t     tag;
  logic          accept;
  logic [31:0]   rd_a, rd_b;

  assign accept = in_valid && in_ready;
  assign lo_idx = read_position[PW-1:FRACTION_BITS];
  assign hi_idx = (lo_idx == LAST) ? '0 : lo_idx + 1'b1;

  always_comb begin
    tag.lo_fwd = (lo_idx == write_index);
    tag.lo_hit = ({1'b0, lo_idx} < fill);
    tag.hi_fwd = (hi_idx == write_index);
    tag.hi_hit = ({1'b0, hi_idx} < fill);
  end

  always_comb begin
    write_index_next = (write_index == LAST) ? '0 : write_index + 1'b1;
    pos_sum          = {1'b0, read_position} + {1'b0, ratio};
    if (pos_sum >= SPAN[PW:0]) begin
      pos_sum = pos_sum - SPAN[PW:0];
    end
    read_position_next = pos_sum[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio         <= reduce_ratio(RATIO_RESET);
      read_position <= '0;
      write_index   <= '0;
      fill          <= '0;
    end else begin
      if (cfg_we) ratio <= reduce_ratio(cfg_wdata);
      if (accept) begin
        read_position <= read_position_next;
        write_index   <= write_index_next;
        if (fill != FULL) fill <= fill + 1'b1;
      end
    end
  end

  dlps_store #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (accept),
    .waddr   (write_index),
    .wdata   (frame_in[31:0]),
    .re      (accept),
    .raddr_a (lo_idx),
    .raddr_b (hi_idx),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  dlps_interp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (frame_in[31:0]),
    .frac      (read_position[FRACTION_BITS-1:0]),
    .tag       (tag),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_out (frame_out)
  );

  a_fill_max : assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count overrun");

  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    {1'b0, read_position} < SPAN[PW:0])
    else $error("read position outside the store");

  a_wi_step : assert property (@(posedge clk) disable iff (rst)
    accept |=> (write_index == (($past(write_index) == LAST) ? '0
                                : $past(write_index) + 1'b1)))
    else $error("write index did not advance");

endmodule

// ===== verif/dlps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlps_checker
// Watches the input, output and register ports of the delay-line pitch
// shifter. Every accepted input item runs through a local model of the
// sample store and the interpolating read tap. The expected output frames
// wait in order and are compared with each accepted output item.
// ----------------------------------------------------------------------------
module dlps_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [dlps_pkg::FRAME_W-1:0]  frame_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dlps_pkg::FRAME_W-1:0]  frame_out,
  input  logic                          cfg_we,
  input  logic [dlps_pkg::RATIO_W-1:0]  cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked
);

  localparam int DEPTH = dlps_pkg::DELAY_DEPTH_DEF;
  localparam int FB    = dlps_pkg::FRACTION_BITS_DEF;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = IDX_W + FB;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  logic [dlps_pkg::SAMPLE_W-1:0] tap_store [DEPTH];
  logic [IDX_W-1:0]              wr_idx;
  logic [POS_W-1:0]              rd_pos;
  logic [dlps_pkg::RATIO_W-1:0]  step_ratio;
  logic [dlps_pkg::FRAME_W-1:0]  frames_due [$];

  function automatic logic [dlps_pkg::FRAME_W-1:0] predict_shifted_frame(
    input logic [dlps_pkg::SAMPLE_W-1:0] sample
  );
    logic [IDX_W-1:0]              lo;
    logic [IDX_W-1:0]              hi;
    longint                        a;
    longint                        b;
    longint                        frac;
    longint                        y;
    logic [dlps_pkg::SAMPLE_W-1:0] res;
    tap_store[wr_idx] = sample;
    lo   = rd_pos[POS_W-1:FB];
    hi   = lo + 1'b1;
    frac = rd_pos[FB-1:0];
    a    = $signed(tap_store[lo]);
    b    = $signed(tap_store[hi]);
    y    = a + (((b - a) * frac) >>> FB);
    if (y > SAT_MAX) y = SAT_MAX;
    if (y < SAT_MIN) y = SAT_MIN;
    res    = y[dlps_pkg::SAMPLE_W-1:0];
    wr_idx = wr_idx + 1'b1;
    rd_pos = rd_pos + POS_W'(step_ratio);
    return {res, res};
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [dlps_pkg::FRAME_W-1:0] got,
                                 input logic [dlps_pkg::FRAME_W-1:0] want);
    $display("MISMATCH %s at %0t: frame_out %h, expected %h", what, $time, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [dlps_pkg::FRAME_W-1:0] want;
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) tap_store[k] = '0;
      wr_idx     = '0;
      rd_pos     = '0;
      step_ratio = dlps_pkg::RATIO_RESET;
      frames_due.delete();
    end else begin
      if (cfg_we) step_ratio = cfg_wdata;
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected item", frame_out, '0);
        end else begin
          want = frames_due.pop_front();
          results_checked++;
          if (frame_out !== want) report_mismatch("data", frame_out, want);
        end
      end
      if (in_valid && in_ready) frames_due.push_back(predict_shifted_frame(frame_in[31:0]));
    end
    pending <= frames_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the delay-line pitch shifter. A directed run of
// extreme samples under the reset, zero, maximum and unity pitch ratios is
// followed by random frames over several ratios, with random gaps on the
// input and stalls on the output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT       = 300000;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 67;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [dlps_pkg::FRAME_W-1:0]  frame_in  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dlps_pkg::FRAME_W-1:0]  frame_out;
  logic                          cfg_we    = 1'b0;
  logic [dlps_pkg::RATIO_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending;
  int results_checked;
  int send_gap;
  int recv_gap;
  int frames_sent;
  int ratio_writes;
  int cycle_count;

  logic [31:0] extreme_samples [6] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};

  logic [dlps_pkg::RATIO_W-1:0] directed_ratio [3] = '{18'd0, 18'h3FFFF, 18'd65536};

  delay_line_pitch_shifter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .frame_in  (frame_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_out (frame_out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dlps_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .frame_in        (frame_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_out       (frame_out),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_frame(input logic [dlps_pkg::FRAME_W-1:0] data);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_in <= data;
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [dlps_pkg::RATIO_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ratio_writes++;
  endtask

  function automatic logic [31:0] random_sample;
    case ($urandom_range(9))
      0, 1:    return extreme_samples[$urandom_range(5)];
      2, 3:    return 32'($signed($urandom_range(512)) - 256);
      4:       return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dlps_pkg::RATIO_W-1:0] random_ratio;
    case ($urandom_range(4))
      0:       return 18'd65536;
      1:       return 18'($urandom_range(32768, 131072));
      2:       return 18'($urandom_range(1, 255));
      default: return 18'($urandom_range(262143));
    endcase
  endfunction

  initial begin
    send_gap = 18;
    recv_gap = 46;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 6; k++)
      send_frame({k[0] ? 32'hFFFF_FFFF : 32'h0000_0000, extreme_samples[k]});
    for (int r = 0; r < 3; r++) begin
      write_ratio(directed_ratio[r]);
      for (int k = 0; k < 5; k++)
        send_frame({$urandom, extreme_samples[(k + r) % 6]});
    end

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0:       begin send_gap = 18; recv_gap = 46; end
        1:       begin send_gap = 46; recv_gap = 18; end
        default: begin send_gap = 0;  recv_gap = 0;  end
      endcase
      case (p)
        2:       write_ratio(18'h3FFFF);
        5:       write_ratio(18'd0);
        7:       write_ratio(18'd65536);
        default: write_ratio(random_ratio());
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_frame({$urandom, random_sample()});
    end

    drain();
    $display("Covered %0d frames under %0d pitch ratio writes plus the reset ratio",
             frames_sent, ratio_writes);
    $display("Checked %0d output frames; %0d mismatches, %0d left outstanding",
             results_checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
